/* hdl/vts_pkg.sv */
// ----------------------------------------------------------------------------
// Volume trilinear sampler package
// Shared constants, codes and the per-axis grid split function.
// ----------------------------------------------------------------------------
package vts_pkg;

    localparam int ADDR_W      = 18;
    localparam int STORE_DEPTH = 262144;
    localparam int COORD_W     = 10;
    localparam int W_W         = 17;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 24;

    localparam logic [W_W-1:0] Q_ONE = 17'd65536;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_X = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd3;
    localparam logic [2:0] CFG_GAIN_X   = 3'd4;
    localparam logic [2:0] CFG_GAIN_Y   = 3'd5;
    localparam logic [2:0] CFG_GAIN_Z   = 3'd6;

    // Storage modes.
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_U8   = 2'd1;
    localparam logic [1:0] MODE_U16  = 2'd2;

    // Request kinds.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Reciprocal of 255 scaled by 2^32, rounded up.
    localparam logic [24:0] RECIP_255 = 25'd16843010;

    typedef struct packed {
        logic [COORD_W-1:0] lo;
        logic [W_W-1:0]     w;
        logic               clamp;
    } t_axis;

    typedef struct packed {
        logic [W_W-1:0] wx;
        logic [W_W-1:0] wy;
        logic [W_W-1:0] wz;
        logic           clamp;
    } t_side;

    // Adds the two partial products of (pos - origin) * gain, clamps to the
    // grid and splits into a cell index and a Q1.16 weight.
    function automatic t_axis axis_split(logic [47:0] ph, logic [47:0] pl, logic neg,
                                         logic gnz, int dim);
        logic [48:0] t;
        logic [48:0] top;
        t_axis       r;
        top     = 49'(dim - 1) << 16;
        t       = 49'(ph) + 49'(pl[47:16]);
        r.clamp = 1'b0;
        if (neg) begin
            t       = '0;
            r.clamp = gnz;
        end else if (t > top) begin
            t       = top;
            r.clamp = 1'b1;
        end
        r.lo = t[16 +: COORD_W];
        r.w  = {1'b0, t[15:0]};
        // On the top edge the cell moves down one place with full weight.
        if (r.lo == COORD_W'(dim - 1)) begin
            r.lo = COORD_W'(dim - 2);
            r.w  = Q_ONE;
        end
        return r;
    endfunction

endpackage

/* hdl/volume_trilinear_sampler.sv */
// Each sample beat passes through the pipeline stages in order; its result
// beat is offered from the output register. Throughput: one beat per cycle,
// writes and samples alike; the pipeline stalls as a whole only while a
// finished result waits at the output. The eight neighbors come from eight
// voxel store replicas, one read port each, so all corners are read at once.
// Reset is synchronous, active low; clears valid bits, loads config defaults.
// ----------------------------------------------------------------------------
// Volume trilinear sampler
// Loads a voxel volume through write beats and answers sample beats with a
// trilinearly interpolated, normalized density in Q1.16.
// ----------------------------------------------------------------------------
module volume_trilinear_sampler #(
    parameter int DIM_X = 64,
    parameter int DIM_Y = 64,
    parameter int DIM_Z = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [2:0]                       i_cfg_idx,
    input  logic [31:0]                      i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // voxel_addr[17:0], voxel_value[33:18], pos_x[65:34], pos_y[97:66],
    // pos_z[129:98], zero fill above
    input  logic [vts_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // req_type
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // sample_value[16:0], zero fill above
    output logic [vts_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // clamped
    output logic                             o_m_axis_tuser
);
    import vts_pkg::*;

    localparam logic [ADDR_W-1:0] OFF_Y = ADDR_W'(DIM_X);
    localparam logic [ADDR_W-1:0] OFF_Z = ADDR_W'(DIM_X * DIM_Y);

    logic        en;
    logic [1:0]  r_mode;
    logic [31:0] r_org  [3];
    logic [31:0] r_gain [3];

    // Valid bits: r_wr for write beats up to the store, r_smp for samples.
    logic        r_wr  [1:6];
    logic        r_smp [1:15];

    logic [31:0]       r1_pos [3];
    logic [ADDR_W-1:0] r1_addr, r2_addr, r3_addr, r4_addr;
    logic [15:0]       r1_val, r2_val, r3_val, r4_val, r5_val, r6_val;
    logic [31:0]       r2_ud [3];
    logic              r2_neg [3], r3_neg [3];
    logic [47:0]       r3_ph [3], r3_pl [3];
    logic [COORD_W-1:0] r4_lo [3];
    logic [ADDR_W-1:0] r5_base;
    logic [ADDR_W-1:0] r6_addr [8];
    logic [15:0]       r7_v [8];
    logic [32:0]       r8_p [8];
    logic [32:0]       r9_c [4];
    logic [49:0]       r10_q [4];
    logic [31:0]       r11_e [2];
    logic [48:0]       r12_s [2];
    logic [32:0]       r13_n;
    logic [49:0]       r14_p8;
    logic [16:0]       r14_q1;
    logic [17:0]       r14_rem;
    logic [16:0]       r15_res;
    t_side             r_sd [4:15];

    t_axis             n_ax [3];
    logic [16:0]       n_res;
    logic [15:0]       v_m [8];
    logic [31:0]       n_sum;

    assign en              = !r_smp[15] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_smp[15];
    assign o_m_axis_tdata  = {7'd0, r15_res};
    assign o_m_axis_tuser  = r_sd[15].clamp;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            for (int a = 0; a < 3; a++) begin
                r_org[a]  <= 32'hFFE0_0000;
                r_gain[a] <= 32'd64512;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:     r_mode    <= i_cfg_data[1:0];
                CFG_ORIGIN_X: r_org[0]  <= i_cfg_data;
                CFG_ORIGIN_Y: r_org[1]  <= i_cfg_data;
                CFG_ORIGIN_Z: r_org[2]  <= i_cfg_data;
                CFG_GAIN_X:   r_gain[0] <= i_cfg_data;
                CFG_GAIN_Y:   r_gain[1] <= i_cfg_data;
                CFG_GAIN_Z:   r_gain[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 6; s++) r_wr[s] <= 1'b0;
            for (int s = 1; s <= 15; s++) r_smp[s] <= 1'b0;
        end else if (en) begin
            r_wr[1]  <= i_s_axis_tvalid && (i_s_axis_tuser == REQ_WRITE);
            r_smp[1] <= i_s_axis_tvalid && (i_s_axis_tuser == REQ_SAMPLE);
            for (int s = 2; s <= 6; s++) r_wr[s] <= r_wr[s-1];
            for (int s = 2; s <= 15; s++) r_smp[s] <= r_smp[s-1];
        end
    end

    always_comb begin
        n_ax[0] = axis_split(r3_ph[0], r3_pl[0], r3_neg[0], |r_gain[0], DIM_X);
        n_ax[1] = axis_split(r3_ph[1], r3_pl[1], r3_neg[1], |r_gain[1], DIM_Y);
        n_ax[2] = axis_split(r3_ph[2], r3_pl[2], r3_neg[2], |r_gain[2], DIM_Z);
        for (int k = 0; k < 8; k++) begin
            v_m[k] = (r_mode == MODE_U8) ? {8'd0, r7_v[k][7:0]} : r7_v[k];
        end
        n_sum = 32'((r12_s[0] + r12_s[1] + 49'd32768) >> 16);
        case (r_mode)
            MODE_U8:  n_res = r14_p8[48:32];
            MODE_U16: n_res = r14_q1 + 17'(r14_rem >= 18'd65535)
                                     + 17'(r14_rem >= 18'd131070);
            default:  n_res = '0;
        endcase
    end

    // Datapath; payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (en) begin
            // Stage 1: input register.
            r1_pos[0] <= i_s_axis_tdata[65:34];
            r1_pos[1] <= i_s_axis_tdata[97:66];
            r1_pos[2] <= i_s_axis_tdata[129:98];
            r1_addr   <= i_s_axis_tdata[17:0];
            r1_val    <= i_s_axis_tdata[33:18];
            // Stage 2: offset from the grid origin.
            for (int a = 0; a < 3; a++) begin
                {r2_neg[a], r2_ud[a]} <= {r1_pos[a][31], r1_pos[a]}
                                       - {r_org[a][31], r_org[a]};
            end
            r2_addr <= r1_addr;
            r2_val  <= r1_val;
            // Stage 3: gain split into high and low halves.
            for (int a = 0; a < 3; a++) begin
                r3_ph[a]  <= 48'(r2_ud[a]) * 48'(r_gain[a][31:16]);
                r3_pl[a]  <= 48'(r2_ud[a]) * 48'(r_gain[a][15:0]);
                r3_neg[a] <= r2_neg[a];
            end
            r3_addr <= r2_addr;
            r3_val  <= r2_val;
            // Stage 4: clamp and split into cell and weight.
            for (int a = 0; a < 3; a++) r4_lo[a] <= n_ax[a].lo;
            r_sd[4] <= '{wx: n_ax[0].w, wy: n_ax[1].w, wz: n_ax[2].w,
                         clamp: n_ax[0].clamp | n_ax[1].clamp | n_ax[2].clamp};
            r4_addr <= r3_addr;
            r4_val  <= r3_val;
            // Stage 5: linear address of the base corner, or the write address.
            r5_base <= r_wr[4] ? r4_addr
                     : ADDR_W'(r4_lo[0])
                       + ADDR_W'(ADDR_W'(r4_lo[1]) * OFF_Y)
                       + ADDR_W'(ADDR_W'(r4_lo[2]) * OFF_Z);
            r5_val  <= r4_val;
            // Stage 6: the eight corner addresses; bit 0 x, bit 1 y, bit 2 z.
            for (int k = 0; k < 8; k++) begin
                r6_addr[k] <= r5_base + (k[0] ? ADDR_W'(1) : '0)
                            + (k[1] ? OFF_Y : '0) + (k[2] ? OFF_Z : '0);
            end
            r6_val <= r5_val;
            // Stage 8: x weights.
            for (int k = 0; k < 8; k++) begin
                r8_p[k] <= 33'(v_m[k]) * 33'(k[0] ? r_sd[7].wx : Q_ONE - r_sd[7].wx);
            end
            // Stage 9: x blends.
            for (int j = 0; j < 4; j++) r9_c[j] <= r8_p[2*j] + r8_p[2*j+1];
            // Stage 10: y weights.
            for (int m = 0; m < 4; m++) begin
                r10_q[m] <= 50'(r9_c[m]) * 50'(m[0] ? r_sd[9].wy : Q_ONE - r_sd[9].wy);
            end
            // Stage 11: y blends, rounded half up.
            r11_e[0] <= 32'((r10_q[0] + r10_q[1] + 50'd32768) >> 16);
            r11_e[1] <= 32'((r10_q[2] + r10_q[3] + 50'd32768) >> 16);
            // Stage 12: z weights.
            r12_s[0] <= 49'(r11_e[0]) * 49'(Q_ONE - r_sd[11].wz);
            r12_s[1] <= 49'(r11_e[1]) * 49'(r_sd[11].wz);
            // Stage 13: z blend plus half the divisor.
            r13_n <= 33'(n_sum) + ((r_mode == MODE_U8) ? 33'd127 : 33'd32767);
            // Stage 14: divide by 255 via reciprocal, by 65535 via digit fold.
            r14_p8  <= 50'(r13_n[24:0]) * 50'(RECIP_255);
            r14_q1  <= r13_n[32:16];
            r14_rem <= 18'(r13_n[15:0]) + 18'(r13_n[32:16]);
            // Stage 15: output register.
            r15_res <= n_res;
            for (int s = 5; s <= 15; s++) r_sd[s] <= r_sd[s-1];
        end
    end

    // Eight replicas of the store, all written by every write beat.
    for (genvar k = 0; k < 8; k++) begin : g_bank
        logic [15:0] mem [STORE_DEPTH];
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_wr[6]) begin
                    mem[r6_addr[0]] <= r6_val;
                end
                r7_v[k] <= mem[r6_addr[k]];
            end
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[16:0] <= 17'd65536))
        else $error("sample value above 1.0");
    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (r_mode != MODE_U8) && (r_mode != MODE_U16)
        |-> (o_m_axis_tdata[16:0] == '0))
        else $error("nonzero sample without voxel data");

endmodule

/* tb/volume_trilinear_sampler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume trilinear sampler testbench
// Loads voxels through write beats and checks every sample beat against an
// in-bench predictor of the grid mapping and the trilinear blend. Every voxel
// that a sample touches is written first, so no sample blends an unwritten entry.
// ----------------------------------------------------------------------------
module volume_trilinear_sampler_tb;
    import vts_pkg::*;

    localparam int GRID = 64;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic [16:0] density;
        logic        clip;
    } t_density;

    typedef struct {
        int unsigned lo;
        int unsigned w;
        bit          clip;
    } t_cell;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic         i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic         o_m_axis_tuser;

    volume_trilinear_sampler dut (.*);

    // Predictor state.
    logic [15:0] vox_mem [STORE_DEPTH];
    bit          vox_written [STORE_DEPTH];
    logic [1:0]  cur_mode;
    logic [31:0] cur_origin [3];
    logic [31:0] cur_gain [3];

    t_density density_q[$];
    int       mismatches;
    bit       quiet;
    int       hold_left;
    int       cycles;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = 1'b1;
            #5 i_clk = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_cell map_axis(logic [31:0] pos, logic [31:0] org, logic [31:0] gain);
        longint            d;
        longint unsigned   ud;
        longint unsigned   t;
        longint unsigned   top;
        t_cell             c;
        d      = longint'($signed(pos)) - longint'($signed(org));
        top    = longint'(GRID - 1) << 16;
        c.clip = 1'b0;
        if (d < 0) begin
            t      = 0;
            c.clip = (gain != 0);
        end else begin
            ud = d;
            t  = ud * {48'b0, gain[31:16]} + ((ud * {48'b0, gain[15:0]}) >> 16);
            if (t > top) begin
                t      = top;
                c.clip = 1'b1;
            end
        end
        c.lo = int'(t >> 16);
        c.w  = int'(t & 64'hFFFF);
        if (c.lo == GRID - 1) begin
            c.lo = GRID - 2;
            c.w  = 65536;
        end
        return c;
    endfunction

    function automatic int unsigned corner_addr(t_cell cx, t_cell cy, t_cell cz, int k);
        return ((cx.lo + k[0]) + (cy.lo + k[1]) * GRID + (cz.lo + k[2]) * GRID * GRID)
               & (STORE_DEPTH - 1);
    endfunction

    function automatic longint unsigned corner_val(t_cell cx, t_cell cy, t_cell cz, int k);
        longint unsigned v;
        v = vox_mem[corner_addr(cx, cy, cz, k)];
        if (cur_mode == MODE_U8) v &= 64'hFF;
        return v;
    endfunction

    function automatic longint unsigned mix(longint unsigned a, longint unsigned b, int unsigned w);
        return (a * (65536 - w) + b * w + 32768) >> 16;
    endfunction

    function automatic t_density predict_density(logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz);
        t_cell           cx, cy, cz;
        longint unsigned edge_v [4];
        longint unsigned c0, c1, r, maxv;
        t_density        res;
        cx = map_axis(px, cur_origin[0], cur_gain[0]);
        cy = map_axis(py, cur_origin[1], cur_gain[1]);
        cz = map_axis(pz, cur_origin[2], cur_gain[2]);
        res.clip = cx.clip | cy.clip | cz.clip;
        res.density = '0;
        if (cur_mode == MODE_U8 || cur_mode == MODE_U16) begin
            // Corners along x are blended first, keeping the 2^16 scale.
            for (int j = 0; j < 4; j++)
                edge_v[j] = corner_val(cx, cy, cz, 2 * j) * (65536 - cx.w)
                          + corner_val(cx, cy, cz, 2 * j + 1) * cx.w;
            c0   = mix(edge_v[0], edge_v[1], cy.w);
            c1   = mix(edge_v[2], edge_v[3], cy.w);
            r    = mix(c0, c1, cz.w);
            maxv = (cur_mode == MODE_U8) ? 255 : 65535;
            res.density = 17'((r + maxv / 2) / maxv);
        end
        return res;
    endfunction

    always @(negedge i_clk) begin : sink_ready
        int burst;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            burst = 0;
        end else if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (quiet) begin
            i_m_axis_tready <= 1'b1;
        end else if (burst > 0) begin
            i_m_axis_tready <= 1'b0;
            burst = burst - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_m_axis_tready <= 1'b0;
            burst = $urandom_range(0, 3);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : density_check
        t_density want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (density_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: density %0d clamped %0b",
                             o_m_axis_tdata[16:0], o_m_axis_tuser);
            end else begin
                want = density_q.pop_front();
                if (o_m_axis_tdata[16:0] !== want.density || o_m_axis_tuser !== want.clip
                    || o_m_axis_tdata[OUT_TDATA_W-1:17] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("density mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.density, want.clip, o_m_axis_tdata[16:0],
                                 o_m_axis_tuser);
                end
            end
        end
    end

    task automatic send_beat(logic kind, logic [17:0] addr, logic [15:0] val,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {6'b0, pz, py, px, val, addr};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (kind == REQ_WRITE) begin
            vox_mem[addr]     = val;
            vox_written[addr] = 1'b1;
        end else begin
            density_q.push_back(predict_density(px, py, pz));
        end
        @(negedge i_clk);
    endtask

    task automatic write_voxel(logic [17:0] addr, logic [15:0] val);
        send_beat(REQ_WRITE, addr, val, $urandom, $urandom, $urandom);
    endtask

    // Any corner that was never loaded gets a random value first.
    task automatic sample_at(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        t_cell       cx, cy, cz;
        int unsigned a;
        cx = map_axis(px, cur_origin[0], cur_gain[0]);
        cy = map_axis(py, cur_origin[1], cur_gain[1]);
        cz = map_axis(pz, cur_origin[2], cur_gain[2]);
        for (int k = 0; k < 8; k++) begin
            a = corner_addr(cx, cy, cz, k);
            if (!vox_written[a]) write_voxel(18'(a), 16'($urandom));
        end
        send_beat(REQ_SAMPLE, 18'($urandom), 16'($urandom), px, py, pz);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (density_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_MODE:     cur_mode      = value[1:0];
            CFG_ORIGIN_X: cur_origin[0] = value;
            CFG_ORIGIN_Y: cur_origin[1] = value;
            CFG_ORIGIN_Z: cur_origin[2] = value;
            CFG_GAIN_X:   cur_gain[0]   = value;
            CFG_GAIN_Y:   cur_gain[1]   = value;
            CFG_GAIN_Z:   cur_gain[2]   = value;
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [1:0] mode, logic [31:0] org, logic [31:0] gain);
        set_reg(CFG_MODE, {30'b0, mode});
        set_reg(CFG_ORIGIN_X, org);
        set_reg(CFG_ORIGIN_Y, org);
        set_reg(CFG_ORIGIN_Z, org);
        set_reg(CFG_GAIN_X, gain);
        set_reg(CFG_GAIN_Y, gain);
        set_reg(CFG_GAIN_Z, gain);
    endtask

    // Unit grid: exact top edge, just above, below, extremes; then modes, odd grids.
    task automatic test_directed();
        set_grid(MODE_U16, 32'h0, 32'h0001_0000);
        write_voxel(18'h0, 16'hFFFF);
        write_voxel(18'h3FFFF, 16'h0000);
        sample_at(32'h0, 32'h0, 32'h0);
        sample_at(32'h003F_0000, 32'h003F_0000, 32'h003F_0000);
        sample_at(32'h003F_0001, 32'h0, 32'h0);
        sample_at(32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_8000);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        drain();
        set_reg(CFG_MODE, {30'b0, MODE_U8});
        sample_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        sample_at(32'h0, 32'h0, 32'h0);
        drain();
        set_reg(CFG_MODE, {30'b0, MODE_NONE});
        sample_at(32'h0000_4000, 32'h8000_0000, 32'h0);
        drain();
        set_reg(CFG_MODE, {30'b0, MODE_SPARE});
        sample_at(32'h7FFF_FFFF, 32'h0, 32'h0);
        drain();
        set_grid(MODE_U16, 32'h7FFF_FFFF, 32'h0);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        drain();
        set_grid(MODE_U16, 32'h8000_0000, 32'hFFFF_FFFF);
        sample_at(32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF);
        sample_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drain();
    endtask

    function automatic logic [31:0] pick_pos(int axis);
        if ($urandom_range(0, 3) == 0) return $urandom;
        // Mostly inside the grid, with a margin on either side.
        return cur_origin[axis] + 32'($urandom_range(0, 80 << 16)) - 32'(8 << 16);
    endfunction

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 3)
                write_voxel(18'($urandom), 16'($urandom));
            else
                sample_at(pick_pos(0), pick_pos(1), pick_pos(2));
        end
        drain();
    endtask

    task automatic test_random_configs();
        set_grid(MODE_U8, 32'hFFE0_0000, 32'h0000_FC00);
        test_random(18);
        set_grid(MODE_U16, 32'h0010_0000, 32'h0000_8000);
        set_reg(CFG_GAIN_Y, 32'h0002_0000);
        set_reg(CFG_ORIGIN_Z, $urandom);
        set_reg(CFG_GAIN_Z, $urandom);
        test_random(18);
        set_grid(MODE_U16, $urandom, 32'($urandom_range(32'h4000, 32'h4_0000)));
        test_random(16);
    endtask

    // The sink holds off while samples keep coming, filling the pipeline.
    task automatic test_backpressure();
        set_grid(MODE_U8, 32'hFFE0_0000, 32'h0001_0000);
        hold_left = 90;
        for (int n = 0; n < 12; n++) sample_at(pick_pos(0), pick_pos(1), pick_pos(2));
        drain();
    endtask

    task automatic test_steady();
        quiet = 1'b1;
        set_grid(MODE_U16, 32'hFFF0_0000, 32'h0001_8000);
        test_random(14);
    endtask

    initial begin
        cycles          = 0;
        mismatches      = 0;
        quiet           = 1'b0;
        hold_left       = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_MODE;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = REQ_WRITE;
        cur_mode        = MODE_NONE;
        for (int a = 0; a < 3; a++) begin
            cur_origin[a] = 32'hFFE0_0000;
            cur_gain[a]   = 32'h0000_FC00;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_random_configs();
        test_steady();
        if (mismatches == 0 && density_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
